[rtl/fts_pkg.sv]
// Package for the fence-tagged slot pool: field widths, operation codes and defaults.
// Used by every module of the block; depends on nothing.
package fts_pkg;

   // Field widths of the request and response beats.
   localparam int KIND_W  = 3;
   localparam int SLOT_W  = 4;
   localparam int FENCE_W = 64;
   localparam int COUNT_W = 5;

   // Operation codes carried in the kind field.
   localparam logic [KIND_W-1:0] KIND_ACQUIRE = 3'd0;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SUBMIT  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_RETIRE  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_LIST    = 3'd4;

   // Pool size default, listing cap and the ceiling of the reported count.
   localparam int POOL_SLOTS_DEF = 16;
   localparam int MAX_RESULTS    = 16;
   localparam int RES_CNT_W      = $clog2(MAX_RESULTS);
   localparam int ACT_MAX        = 31;

endpackage

[rtl/fts_tag_store.sv]
// Fence tag store: one synchronous memory with a registered read port and a
// comparator of the read tag against the completed fence value. Depends on fts_pkg.
module fts_tag_store
   import fts_pkg::*;
#(
   parameter int POOL_SLOTS = POOL_SLOTS_DEF,
   localparam int IDX_W = $clog2(POOL_SLOTS)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [IDX_W-1:0]   wr_addr,
   input  logic [FENCE_W-1:0] wr_data,
   input  logic [IDX_W-1:0]   rd_addr,
   input  logic [FENCE_W-1:0] limit,
   output logic               rd_le
);

   logic [FENCE_W-1:0] tag_mem [POOL_SLOTS];
   logic [FENCE_W-1:0] rd_data_ff;

   // One write and one read per cycle; the read data is registered.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         tag_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= tag_mem[rd_addr];
   end

   // The tag read last cycle has completed when it is at or below the limit.
   assign rd_le = (rd_data_ff <= limit);

endmodule

[rtl/fence_tagged_slot_pool_top.sv]
// Fence-tagged slot pool: top level with the operation sequencer and response register.
// Depends on fts_pkg and fts_tag_store.
//
// The pool hands out slots on acquire, closes them on release, tags closed slots with a
// fence value on submit and frees them once the completed fence value reaches the tag.
// One request is worked on at a time. Release and unknown codes go straight to the
// closing beat. Acquire walks the slots from zero upward, one slot per cycle through
// the single read port of the tag memory, and stops at the first slot it grants.
// Retire and submit walk every slot, and a list holds its scan while the response
// side stalls. Busy and tagged marks sit in flip-flops cleared by reset and closed
// marks in flip-flops set by it, so the tag memory needs no clearing pass and the
// block takes requests right after reset. A finished response waits in an output
// register while the next request is taken.
module fence_tagged_slot_pool_top
   import fts_pkg::*;
#(
   parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [KIND_W-1:0]  req_kind,
   input  logic [SLOT_W-1:0]  req_slot,
   input  logic [FENCE_W-1:0] req_fence_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [SLOT_W-1:0]  rsp_result_slot,
   output logic               rsp_slot_valid,
   output logic               rsp_last,
   output logic [COUNT_W-1:0] rsp_active_count
);

   localparam int IDX_W = $clog2(POOL_SLOTS);
   localparam int CNT_W = $clog2(POOL_SLOTS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SLOTS - 1);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ACQ  = 3'd1;
   localparam logic [2:0] ST_RET  = 3'd2;
   localparam logic [2:0] ST_SUB  = 3'd3;
   localparam logic [2:0] ST_LIST = 3'd4;
   localparam logic [2:0] ST_RESP = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [POOL_SLOTS-1:0] busy_ff, busy_in;
   logic [POOL_SLOTS-1:0] closed_ff, closed_in;
   logic [POOL_SLOTS-1:0] tagged_ff, tagged_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [IDX_W-1:0]      ev_idx_ff, ev_idx_in;
   logic                  ev_valid_ff, ev_valid_in;
   logic                  issue_on_ff, issue_on_in;
   logic [RES_CNT_W-1:0]  listed_ff, listed_in;
   logic [FENCE_W-1:0]    fence_ff, fence_in;
   logic [SLOT_W-1:0]     res_slot_ff, res_slot_in;
   logic                  res_valid_ff, res_valid_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic                  rsp_sv_ff, rsp_sv_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;

   logic                  out_free;
   logic                  out_load;
   logic [SLOT_W-1:0]     out_slot;
   logic                  out_sv;
   logic                  out_last;
   logic [COUNT_W-1:0]    act_sat;
   logic                  tag_wr_en;
   logic                  tag_le;
   logic [POOL_SLOTS-1:0] listable;
   logic [POOL_SLOTS-1:0] above;
   logic                  more_above;
   logic                  scanning;
   logic                  ev_hit;

   // Tag memory: written only by submit, read only by acquire and retire.
   fts_tag_store #(
      .POOL_SLOTS(POOL_SLOTS)
   ) u_tags (
      .clock  (clock),
      .wr_en  (tag_wr_en),
      .wr_addr(idx_ff),
      .wr_data(fence_ff),
      .rd_addr(idx_ff),
      .limit  (fence_ff),
      .rd_le  (tag_le)
   );

   // Count seen by the response, capped at the field's ceiling.
   assign act_sat = (32'(count_ff) > 32'(ACT_MAX)) ? COUNT_W'(ACT_MAX) : COUNT_W'(count_ff);

   // Slots that a listing reports, and whether any lies above the current one.
   assign listable   = busy_ff & closed_ff;
   assign above      = listable >> idx_ff;
   assign more_above = |above[POOL_SLOTS-1:1];

   assign scanning = (state_ff == ST_ACQ) || (state_ff == ST_RET);
   assign ev_hit   = busy_ff[ev_idx_ff] & tagged_ff[ev_idx_ff] & tag_le;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // Sequencer: one slot per cycle unless a list waits on the output; tags are read the cycle before use.
   always_comb begin
      state_in     = state_ff;
      busy_in      = busy_ff;
      closed_in    = closed_ff;
      tagged_in    = tagged_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      ev_idx_in    = idx_ff;
      ev_valid_in  = 1'b0;
      issue_on_in  = issue_on_ff;
      listed_in    = listed_ff;
      fence_in     = fence_ff;
      res_slot_in  = res_slot_ff;
      res_valid_in = res_valid_ff;
      tag_wr_en    = 1'b0;
      out_load     = 1'b0;
      out_slot     = '0;
      out_sv       = 1'b0;
      out_last     = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               fence_in     = req_fence_value;
               idx_in       = '0;
               issue_on_in  = 1'b1;
               listed_in    = '0;
               res_slot_in  = '0;
               res_valid_in = 1'b0;
               case (req_kind)
                  KIND_ACQUIRE: state_in = ST_ACQ;
                  KIND_SUBMIT:  state_in = ST_SUB;
                  KIND_RETIRE:  state_in = ST_RET;
                  KIND_LIST:    state_in = ST_LIST;
                  KIND_RELEASE: begin
                     if (32'(req_slot) < POOL_SLOTS) begin
                        closed_in[IDX_W'(req_slot)] = 1'b1;
                     end
                     state_in = ST_RESP;
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end

         ST_ACQ, ST_RET: begin
            // Issue side: step the read address until the last slot is read.
            if (issue_on_ff) begin
               ev_valid_in = 1'b1;
               idx_in      = idx_ff + IDX_W'(1);
               issue_on_in = (idx_ff != LAST_IDX);
            end
            // Evaluate side: the slot whose tag arrived this cycle.
            if (ev_valid_ff) begin
               if (state_ff == ST_ACQ) begin
                  if (!busy_ff[ev_idx_ff] || ev_hit) begin
                     if (!busy_ff[ev_idx_ff]) begin
                        count_in = count_ff + CNT_W'(1);
                     end
                     busy_in[ev_idx_ff]   = 1'b1;
                     closed_in[ev_idx_ff] = 1'b0;
                     tagged_in[ev_idx_ff] = 1'b0;
                     res_slot_in  = SLOT_W'(ev_idx_ff);
                     res_valid_in = 1'b1;
                     ev_valid_in  = 1'b0;
                     state_in     = ST_RESP;
                  end else if (ev_idx_ff == LAST_IDX) begin
                     state_in = ST_RESP;
                  end
               end else begin
                  if (ev_hit && closed_ff[ev_idx_ff]) begin
                     busy_in[ev_idx_ff]   = 1'b0;
                     tagged_in[ev_idx_ff] = 1'b0;
                     count_in = count_ff - CNT_W'(1);
                  end
                  if (ev_idx_ff == LAST_IDX) begin
                     state_in = ST_RESP;
                  end
               end
            end
         end

         ST_SUB: begin
            // Write the submitted fence to each busy, closed, untagged slot; a zero fence leaves it untagged.
            if (busy_ff[idx_ff] && closed_ff[idx_ff] && !tagged_ff[idx_ff]) begin
               tag_wr_en         = 1'b1;
               tagged_in[idx_ff] = (fence_ff != '0);
            end
            idx_in = idx_ff + IDX_W'(1);
            if (idx_ff == LAST_IDX) begin
               state_in = ST_RESP;
            end
         end

         ST_LIST: begin
            // One beat per busy closed slot; hold the scan while the output is full.
            if (listable[idx_ff]) begin
               if (out_free) begin
                  out_load = 1'b1;
                  out_slot = SLOT_W'(idx_ff);
                  out_sv   = 1'b1;
                  out_last = !more_above || (listed_ff == RES_CNT_W'(MAX_RESULTS - 1));
                  listed_in = listed_ff + RES_CNT_W'(1);
                  idx_in    = idx_ff + IDX_W'(1);
                  if (out_last) begin
                     state_in = ST_IDLE;
                  end
               end
            end else begin
               idx_in = idx_ff + IDX_W'(1);
               if (idx_ff == LAST_IDX) begin
                  state_in = ST_RESP;
               end
            end
         end

         ST_RESP: begin
            // Single closing beat of every operation but a non-empty listing.
            if (out_free) begin
               out_load = 1'b1;
               out_slot = res_slot_ff;
               out_sv   = res_valid_ff;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      if (!scanning) begin
         ev_valid_in = 1'b0;
      end
   end

   // Response register: loaded by the sequencer, drained by the consumer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_sv_in    = rsp_sv_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_count_in = rsp_count_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_slot_in  = out_slot;
         rsp_sv_in    = out_sv;
         rsp_last_in  = out_last;
         rsp_count_in = act_sat;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= '0;
         closed_ff    <= '1;
         tagged_ff    <= '0;
         count_ff     <= '0;
         ev_valid_ff  <= 1'b0;
         issue_on_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         closed_ff    <= closed_in;
         tagged_ff    <= tagged_in;
         count_ff     <= count_in;
         ev_valid_ff  <= ev_valid_in;
         issue_on_ff  <= issue_on_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and scan registers.
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      ev_idx_ff    <= ev_idx_in;
      listed_ff    <= listed_in;
      fence_ff     <= fence_in;
      res_slot_ff  <= res_slot_in;
      res_valid_ff <= res_valid_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_sv_ff    <= rsp_sv_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_slot  = rsp_slot_ff;
   assign rsp_slot_valid   = rsp_sv_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_active_count = rsp_count_ff;

endmodule

[rtl/fts_checker.sv]
// Port-level checker for the fence-tagged slot pool, bound to the top level.
// Depends on fts_pkg for field widths and on the top level's port names.
module fts_checker
   import fts_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [SLOT_W-1:0]  rsp_result_slot,
   input logic               rsp_slot_valid,
   input logic               rsp_last,
   input logic [COUNT_W-1:0] rsp_active_count
);

   // A stalled response beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_slot)
         && $stable(rsp_slot_valid) && $stable(rsp_last) && $stable(rsp_active_count))
      else $error("response beat changed while stalled");

   // The block works on one request at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in progress");

   // A beat without a slot is always the closing beat and names slot zero.
   a_no_slot_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_slot_valid |-> rsp_last && (rsp_result_slot == '0))
      else $error("slotless beat is not a closing beat on slot zero");

   // A granted or listed slot is busy, so the pool cannot be empty.
   a_slot_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_slot_valid |-> rsp_active_count != '0)
      else $error("slot reported while no slot is busy");

endmodule

bind fence_tagged_slot_pool_top fts_checker u_fts_checker (.*);

[tb/sv/fence_tagged_slot_pool_top_test.sv]
// Self-checking testbench for the fence-tagged slot pool top level.
// Depends on fts_pkg and fence_tagged_slot_pool_top; an internal scoreboard predicts each beat.
module fence_tagged_slot_pool_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import fts_pkg::*;

   localparam int SLOTS = POOL_SLOTS_DEF;
   // Codes above list are reserved and must leave the pool untouched.
   localparam logic [KIND_W-1:0] KIND_RSVD_FIRST = KIND_LIST + 3'd1;
   localparam logic [KIND_W-1:0] KIND_RSVD_LAST  = '1;
   localparam logic [FENCE_W-1:0] FENCE_MAX = '1;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int CHUNK_LEN = 40;
   localparam int TAIL_CYCLES = 2 * SLOTS + 8;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [KIND_W-1:0]  req_kind = '0;
   logic [SLOT_W-1:0]  req_slot = '0;
   logic [FENCE_W-1:0] req_fence_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [SLOT_W-1:0]  rsp_result_slot;
   logic               rsp_slot_valid;
   logic               rsp_last;
   logic [COUNT_W-1:0] rsp_active_count;

   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   logic [FENCE_W-1:0] fence_ctr = '0;

   // Mirror of the pool state plus the queue of response beats still owed.
   class slot_pool_scoreboard;
      typedef struct packed {
         logic [SLOT_W-1:0]  slot;
         logic               valid;
         logic               last;
         logic [COUNT_W-1:0] count;
      } pool_rsp_type;

      bit                 busy[SLOTS];
      bit                 closed[SLOTS];
      logic [FENCE_W-1:0] tag[SLOTS];
      pool_rsp_type       owed_q[$];
      int                 errors;

      function new();
         for (int i = 0; i < SLOTS; i++) begin
            busy[i]   = 1'b0;
            closed[i] = 1'b1;
            tag[i]    = '0;
         end
         errors = 0;
      endfunction

      function int pending();
         return owed_q.size();
      endfunction

      // Work out the beats one accepted request causes and update the mirror.
      function void note_request(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot,
                                 logic [FENCE_W-1:0] fv);
         pool_rsp_type beats[$];
         pool_rsp_type one;
         bit granted;
         int n_busy;
         granted = 1'b0;
         one = '0;
         case (kind)
            KIND_ACQUIRE: begin
               // Scan upward, retiring completed slots until the first free one is granted.
               for (int i = 0; i < SLOTS && !granted; i++) begin
                  if (busy[i] && tag[i] != '0 && tag[i] <= fv) begin
                     busy[i] = 1'b0;
                     tag[i]  = '0;
                  end
                  if (!busy[i]) begin
                     busy[i]   = 1'b1;
                     closed[i] = 1'b0;
                     tag[i]    = '0;
                     one.slot  = SLOT_W'(i);
                     one.valid = 1'b1;
                     granted   = 1'b1;
                  end
               end
               one.last = 1'b1;
               beats = {beats, one};
            end
            KIND_RELEASE: begin
               if (int'(slot) < SLOTS) closed[slot] = 1'b1;
               one.last = 1'b1;
               beats = {beats, one};
            end
            KIND_SUBMIT: begin
               for (int i = 0; i < SLOTS; i++)
                  if (busy[i] && closed[i] && tag[i] == '0) tag[i] = fv;
               one.last = 1'b1;
               beats = {beats, one};
            end
            KIND_RETIRE: begin
               for (int i = 0; i < SLOTS; i++)
                  if (busy[i] && closed[i] && tag[i] != '0 && tag[i] <= fv) begin
                     busy[i] = 1'b0;
                     tag[i]  = '0;
                  end
               one.last = 1'b1;
               beats = {beats, one};
            end
            KIND_LIST: begin
               // One beat per busy closed slot, capped at the listing limit.
               for (int i = 0; i < SLOTS && beats.size() < MAX_RESULTS; i++)
                  if (busy[i] && closed[i]) begin
                     one.slot  = SLOT_W'(i);
                     one.valid = 1'b1;
                     beats = {beats, one};
                  end
               if (beats.size() == 0) begin
                  one.last = 1'b1;
                  beats = {beats, one};
               end else begin
                  beats[beats.size()-1].last = 1'b1;
               end
            end
            default: begin
               one.last = 1'b1;
               beats = {beats, one};
            end
         endcase
         // The count reflects the pool after the whole step.
         n_busy = 0;
         for (int i = 0; i < SLOTS; i++) if (busy[i]) n_busy++;
         if (n_busy > ACT_MAX) n_busy = ACT_MAX;
         foreach (beats[k]) begin
            beats[k].count = COUNT_W'(n_busy);
            owed_q = {owed_q, beats[k]};
         end
      endfunction

      function void compare_field(string name, logic [FENCE_W-1:0] exp_v,
                                  logic [FENCE_W-1:0] act_v);
         if (act_v !== exp_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
         end
      endfunction

      // Compare one accepted response beat with the oldest owed beat.
      function void check_result(logic [SLOT_W-1:0] slot, logic valid, logic last,
                                 logic [COUNT_W-1:0] count);
         pool_rsp_type want;
         if (owed_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat, expected none, actual slot %0d valid %0b %s",
                     $time, slot, valid,
                     $sformatf("last %0b count %0d", last, count));
            return;
         end
         want = owed_q.pop_front();
         compare_field("result_slot", FENCE_W'(want.slot), FENCE_W'(slot));
         compare_field("slot_valid", FENCE_W'(want.valid), FENCE_W'(valid));
         compare_field("last", FENCE_W'(want.last), FENCE_W'(last));
         compare_field("active_count", FENCE_W'(want.count), FENCE_W'(count));
      endfunction
   endclass

   slot_pool_scoreboard pool_sb = new();

   fence_tagged_slot_pool_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_slot        (req_slot),
      .req_fence_value (req_fence_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_slot (rsp_result_slot),
      .rsp_slot_valid  (rsp_slot_valid),
      .rsp_last        (rsp_last),
      .rsp_active_count(rsp_active_count)
   );

   always #6 clock = ~clock;

   // Response side: check each accepted beat, then pick the next ready value.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            pool_sb.check_result(rsp_result_slot, rsp_slot_valid, rsp_last, rsp_active_count);
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Present one request beat after a random idle gap and hold it until accepted.
   task automatic send_request(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot,
                               logic [FENCE_W-1:0] fv);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_slot        <= slot;
      req_fence_value <= fv;
      do @(posedge clock); while (!req_ready);
      pool_sb.note_request(kind, slot, fv);
   endtask

   // Hold off the sender until every owed beat has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pool_sb.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [FENCE_W-1:0] rand_fence();
      return {$urandom, $urandom};
   endfunction

   // Completed fence value: mostly trailing the submit counter, sometimes extreme.
   function automatic logic [FENCE_W-1:0] pick_completed();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return FENCE_MAX;
         2, 3:    return rand_fence();
         default: return fence_ctr - FENCE_W'($urandom_range(0, 3));
      endcase
   endfunction

   // Tag for a submit: normally the next counter value, sometimes zero, maximum or random.
   function automatic logic [FENCE_W-1:0] pick_tag();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return FENCE_MAX;
         2, 3:    return rand_fence();
         default: begin
            fence_ctr = fence_ctr + FENCE_W'($urandom_range(1, 3));
            return fence_ctr;
         end
      endcase
   endfunction

   // Random traffic in chunks: filling, draining, noise, and a close-all sweep with a list.
   task automatic run_random(int n_items);
      int mode;
      int step;
      int r;
      int sweep_base;
      logic [KIND_W-1:0]  kind;
      logic [SLOT_W-1:0]  slot;
      logic [FENCE_W-1:0] fv;
      mode = 0;
      step = 0;
      sweep_base = 0;
      fence_ctr = $urandom_range(0, 1) ? rand_fence() : FENCE_W'($urandom_range(1, 1000));
      for (int n = 0; n < n_items; n++) begin
         if (step == CHUNK_LEN) step = 0;
         if (step == 0) begin
            mode = $urandom_range(0, 3);
            sweep_base = $urandom_range(0, SLOTS - 1);
         end
         r = $urandom_range(0, 99);
         slot = SLOT_W'($urandom_range(0, SLOTS - 1));
         fv = '0;
         case (mode)
            0: begin
               // Acquire-heavy with little retirement, so the pool runs full.
               if (r < 55) begin
                  kind = KIND_ACQUIRE;
                  fv = ($urandom_range(0, 3) == 0) ? pick_completed() : '0;
               end else if (r < 75) kind = KIND_RELEASE;
               else if (r < 85) kind = KIND_LIST;
               else if (r < 92) begin
                  kind = KIND_SUBMIT;
                  fv = pick_tag();
               end else begin
                  kind = KIND_RETIRE;
                  fv = pick_completed();
               end
            end
            1: begin
               // Close, tag and retire slots.
               if (r < 15) begin
                  kind = KIND_ACQUIRE;
                  fv = pick_completed();
               end else if (r < 50) kind = KIND_RELEASE;
               else if (r < 70) begin
                  kind = KIND_SUBMIT;
                  fv = pick_tag();
               end else if (r < 88) begin
                  kind = KIND_RETIRE;
                  fv = pick_completed();
               end else kind = KIND_LIST;
            end
            2: begin
               // Any code, any slot, any fence value.
               kind = KIND_W'($urandom_range(0, 7));
               fv = $urandom_range(0, 1) ? rand_fence() : pick_completed();
            end
            default: begin
               // Close every slot, list them, then tag and retire, then refill.
               if (step < SLOTS) begin
                  kind = KIND_RELEASE;
                  slot = SLOT_W'((sweep_base + step) % SLOTS);
               end else if (step == SLOTS) kind = KIND_LIST;
               else if (step == SLOTS + 1) begin
                  kind = KIND_SUBMIT;
                  fv = pick_tag();
               end else if (step == SLOTS + 2) begin
                  kind = KIND_RETIRE;
                  fv = pick_completed();
               end else begin
                  kind = (r < 70) ? KIND_ACQUIRE : KIND_LIST;
                  fv = (r < 35) ? '0 : pick_completed();
               end
            end
         endcase
         send_request(kind, slot, fv);
         step++;
      end
   endtask

   // Main sequence: reset, directed cases, then random phases under each idling pattern.
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty list, grants, zero and maximum tags, retirement during a scan.
      send_request(KIND_LIST, 4'd0, '0);
      send_request(KIND_ACQUIRE, 4'd15, '0);
      send_request(KIND_ACQUIRE, 4'd0, FENCE_MAX);
      send_request(KIND_RELEASE, 4'd0, FENCE_MAX);
      send_request(KIND_SUBMIT, 4'd15, '0);
      send_request(KIND_LIST, 4'd15, FENCE_MAX);
      send_request(KIND_SUBMIT, 4'd0, FENCE_MAX);
      send_request(KIND_RETIRE, 4'd0, FENCE_MAX - 64'd1);
      send_request(KIND_ACQUIRE, 4'd0, FENCE_MAX);
      send_request(KIND_RELEASE, 4'd1, '0);
      send_request(KIND_SUBMIT, 4'd0, 64'd1);
      send_request(KIND_RETIRE, 4'd0, 64'd1);
      send_request(KIND_RELEASE, 4'd15, '0);
      send_request(KIND_LIST, 4'd0, '0);
      for (int k = KIND_RSVD_FIRST; k <= KIND_RSVD_LAST; k++)
         send_request(KIND_W'(k), 4'd15, FENCE_MAX);
      send_request(KIND_ACQUIRE, 4'd10, 64'hAAAA_AAAA_AAAA_AAAA);
      send_request(KIND_RELEASE, 4'd10, 64'h5555_5555_5555_5555);
      send_request(KIND_SUBMIT, 4'd5, 64'h8000_0000_0000_0000);
      send_request(KIND_RETIRE, 4'd5, 64'h7FFF_FFFF_FFFF_FFFF);
      send_request(KIND_LIST, 4'd5, 64'h8000_0000_0000_0000);
      wait_drained();

      // Random phases: no idling, idle sender, stalling receiver, both lightly.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 88; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 88; end
            default: begin req_idle_pct = 8; rsp_stall_pct = 8; end
         endcase
         run_random(ITEMS_PER_PHASE);
         wait_drained();
      end

      rsp_stall_pct = 0;
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pool_sb.errors == 0 && pool_sb.pending() == 0) begin
         $display("fence_tagged_slot_pool_top regression: pass");
      end else begin
         $display("fence_tagged_slot_pool_top regression: fail");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #50_000_000;
      $display("fence_tagged_slot_pool_top regression: fail");
      $finish;
   end

endmodule

[files.f]
rtl/fts_pkg.sv
rtl/fts_tag_store.sv
rtl/fence_tagged_slot_pool_top.sv
rtl/fts_checker.sv
tb/sv/fence_tagged_slot_pool_top_test.sv
